// ===== hw/rtl/apm_pkg.sv =====
// ----------------------------------------------------------------------------
// apm_pkg
// shared types, constants and helpers of the approximate primer matcher
// ----------------------------------------------------------------------------
`default_nettype none

package apm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int COST_W      = 7;
    localparam int POS_W       = 16;
    localparam int K_W         = 6;
    localparam int LEN_W       = 7;
    localparam int CODE_W      = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CODES_WORDS = 4;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODES_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODES_SECOND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODES_THIRD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODES_HIGH     = 3'd6;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic [CODE_W-1:0] MASK_A    = 4'b0001;
    localparam logic [CODE_W-1:0] MASK_C    = 4'b0010;
    localparam logic [CODE_W-1:0] MASK_G    = 4'b0100;
    localparam logic [CODE_W-1:0] MASK_T    = 4'b1000;
    localparam logic [CODE_W-1:0] MASK_NONE = 4'b0000;

    typedef logic [COST_W-1:0] t_cost;

    typedef struct packed {
        logic [IDX_W-1:0] last_idx;
        logic [K_W-1:0]   max_diff;
        logic [POS_W-1:0] search_limit;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_cost            data;
    } t_mem_wr;

    function automatic logic [CODE_W-1:0] base_mask(input logic [7:0] ch);
        logic [CODE_W-1:0] m;
        case (ch)
            CHAR_A:  m = MASK_A;
            CHAR_C:  m = MASK_C;
            CHAR_G:  m = MASK_G;
            CHAR_T:  m = MASK_T;
            default: m = MASK_NONE;
        endcase
        return m;
    endfunction

    // last used row index, length clamped to 1..PATTERN_MAX
    function automatic logic [IDX_W-1:0] last_row(input logic [LEN_W-1:0] len);
        logic [IDX_W-1:0] r;
        if (len == '0) begin
            r = '0;
        end else if (len > LEN_W'(PATTERN_MAX)) begin
            r = IDX_W'(PATTERN_MAX - 1);
        end else begin
            r = IDX_W'(len - LEN_W'(1));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/apm_cfg.sv =====
// ----------------------------------------------------------------------------
// apm_cfg
// configuration registers and primer code lookup
// ----------------------------------------------------------------------------
`default_nettype none

module apm_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [apm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [apm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic [apm_pkg::IDX_W-1:0]           i_code_idx,
    output apm_pkg::t_cfg                            o_cfg,
    output logic [apm_pkg::CODE_W-1:0]               o_code
);

    logic [apm_pkg::LEN_W-1:0]      r_len;
    logic [apm_pkg::K_W-1:0]        r_max_diff;
    logic [apm_pkg::POS_W-1:0]      r_limit;
    logic [apm_pkg::CFG_DATA_W-1:0] r_codes [apm_pkg::CODES_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= apm_pkg::LEN_W'(1);
            r_max_diff <= '0;
            r_limit    <= '1;
            for (int w = 0; w < apm_pkg::CODES_WORDS; w++) begin
                r_codes[w] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                apm_pkg::REG_PATTERN_LENGTH: r_len      <= i_cfg_data[apm_pkg::LEN_W-1:0];
                apm_pkg::REG_MAX_DIFF:       r_max_diff <= i_cfg_data[apm_pkg::K_W-1:0];
                apm_pkg::REG_SEARCH_LIMIT:   r_limit    <= i_cfg_data[apm_pkg::POS_W-1:0];
                apm_pkg::REG_CODES_LOW:      r_codes[0] <= i_cfg_data;
                apm_pkg::REG_CODES_SECOND:   r_codes[1] <= i_cfg_data;
                apm_pkg::REG_CODES_THIRD:    r_codes[2] <= i_cfg_data;
                apm_pkg::REG_CODES_HIGH:     r_codes[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.last_idx     = apm_pkg::last_row(r_len);
        o_cfg.max_diff     = r_max_diff;
        o_cfg.search_limit = r_limit;
        o_code = r_codes[i_code_idx[5:4]][{i_code_idx[3:0], 2'b00} +: apm_pkg::CODE_W];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/apm_cost_mem.sv =====
// ----------------------------------------------------------------------------
// apm_cost_mem
// edit-distance column memory, registered read, per-entry valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module apm_cost_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  apm_pkg::t_mem_wr                   i_wr,
    input  wire logic [apm_pkg::IDX_W-1:0]     i_raddr,
    output apm_pkg::t_cost                     o_rdata
);

    apm_pkg::t_cost                   r_mem [apm_pkg::PATTERN_MAX];
    apm_pkg::t_cost                   r_rdata;
    logic [apm_pkg::IDX_W-1:0]        r_raddr;
    logic [apm_pkg::PATTERN_MAX-1:0]  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
        r_raddr <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // entry never written since restart reads as row index plus one
    assign o_rdata = r_valid[r_raddr] ? r_rdata
                                      : apm_pkg::COST_W'({1'b0, r_raddr} + 7'd1);

endmodule

`default_nettype wire

// ===== hw/rtl/apm_cell.sv =====
// ----------------------------------------------------------------------------
// apm_cell
// one edit-distance recurrence step for a primer row
// ----------------------------------------------------------------------------
`default_nettype none

module apm_cell (
    input  wire logic [apm_pkg::CODE_W-1:0] i_code,
    input  wire logic [apm_pkg::CODE_W-1:0] i_mask,
    input  apm_pkg::t_cost                  i_diag,
    input  apm_pkg::t_cost                  i_above,
    input  apm_pkg::t_cost                  i_old,
    output apm_pkg::t_cost                  o_cost
);

    apm_pkg::t_cost m;

    always_comb begin
        m = i_diag;
        if (i_old < m) begin
            m = i_old;
        end
        if (i_above < m) begin
            m = i_above;
        end
        if ((i_code & i_mask) != '0) begin
            o_cost = i_diag;
        end else begin
            o_cost = m + apm_pkg::COST_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/approx_pattern_match_iupac.sv =====
// ----------------------------------------------------------------------------
// approx_pattern_match_iupac
// semi-global k-differences primer search over a stream of read bases
// ----------------------------------------------------------------------------
// Read bases enter on the s_axis channel, one ASCII base per word; tuser
// restarts the read, tlast marks its final base. Registers are written on
// the cfg channel (always ready), by the user only while the block is idle;
// the block does not enforce it. The cost column is a 64-entry memory. Each
// searched base sweeps the column one row per cycle (read, update, write
// back), then a finish step, the only step of a base past the search limit.
// On a last base the result (found flag, earliest end position) is loaded
// into the m_axis output register in its finish step. The next base is
// taken while a result waits; if a second result is due while the first
// is still stalled, the block holds in its finish step until the output
// frees. Reset loads register defaults and starts a fresh read; the column
// is restarted by clearing per-row valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module approx_pattern_match_iupac (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [apm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // read_base
    input  wire logic                               s_axis_tuser,  // first_of_read
    input  wire logic                               s_axis_tlast,  // last_of_read
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [apm_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // match_found, match_end_position
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [apm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [apm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                          r_state;
    logic [apm_pkg::IDX_W-1:0]       r_idx;
    logic [apm_pkg::CODE_W-1:0]      r_mask;
    logic                            r_last;
    logic [apm_pkg::POS_W-1:0]       r_pos;
    logic                            r_found;
    logic [apm_pkg::POS_W-1:0]       r_first_end;
    apm_pkg::t_cost                  r_diag;
    apm_pkg::t_cost                  r_above;
    logic                            r_out_valid;
    logic                            r_out_found;
    logic [apm_pkg::POS_W-1:0]       r_out_pos;

    apm_pkg::t_cfg                   cfg;
    logic [apm_pkg::CODE_W-1:0]      code;
    apm_pkg::t_cost                  old_cost;
    apm_pkg::t_cost                  new_cost;
    apm_pkg::t_mem_wr                mem_wr;
    logic [apm_pkg::IDX_W-1:0]       mem_raddr;
    logic                            mem_clear;
    logic                            accept;
    logic                            out_free;
    logic                            out_load;
    logic [apm_pkg::POS_W-1:0]       eff_pos;
    logic [apm_pkg::POS_W-1:0]       n_pos;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == S_FINISH) && r_last && out_free;
    assign eff_pos       = s_axis_tuser ? '0 : r_pos;
    assign n_pos         = (r_pos == '1) ? r_pos : r_pos + apm_pkg::POS_W'(1);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_pos, r_out_found};

    apm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_code_idx  (r_idx),
        .o_cfg       (cfg),
        .o_code      (code)
    );

    apm_cell u_cell (
        .i_code  (code),
        .i_mask  (r_mask),
        .i_diag  (r_diag),
        .i_above (r_above),
        .i_old   (old_cost),
        .o_cost  (new_cost)
    );

    always_comb begin
        mem_wr.we   = (r_state == S_SCAN);
        mem_wr.addr = r_idx;
        mem_wr.data = new_cost;
        mem_raddr   = accept ? '0 : r_idx + apm_pkg::IDX_W'(1);
        mem_clear   = (accept && s_axis_tuser) || out_load;
    end

    apm_cost_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (mem_clear),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (old_cost)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_last      <= 1'b0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_first_end <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser) begin
                            r_found     <= 1'b0;
                            r_first_end <= '0;
                        end
                        r_pos   <= eff_pos;
                        r_mask  <= apm_pkg::base_mask(s_axis_tdata);
                        r_last  <= s_axis_tlast;
                        r_diag  <= '0;
                        r_above <= '0;
                        r_idx   <= '0;
                        r_state <= (eff_pos < cfg.search_limit) ? S_SCAN : S_FINISH;
                    end
                end
                S_SCAN: begin
                    r_diag  <= old_cost;
                    r_above <= new_cost;
                    r_idx   <= r_idx + apm_pkg::IDX_W'(1);
                    if (r_idx == cfg.last_idx) begin
                        if (new_cost <= {1'b0, cfg.max_diff} && !r_found) begin
                            r_found     <= 1'b1;
                            r_first_end <= r_pos;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_last) begin
                        r_pos   <= n_pos;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_found <= r_found;
                        r_out_pos   <= r_found ? r_first_end : '0;
                        r_pos       <= '0;
                        r_found     <= 1'b0;
                        r_first_end <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // column write never collides with a restart of the column
    a_no_wr_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_wr.we && mem_clear))
        else $error("column write during restart");

    // sweep stays within the configured primer
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= cfg.last_idx))
        else $error("row index beyond primer length");

    // a result is produced only by the finish step of a last base
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH && r_last))
        else $error("result without last base");

    // recorded end never lies ahead of the current position
    a_end_before_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_first_end <= r_pos))
        else $error("end position ahead of read position");

endmodule

`default_nettype wire
